// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== hw/rtl/wdf_pkg.sv =====
// Constants shared by the WebSocket frame deframer and its checker.
package wdf_pkg;

   // Parse phases.
   localparam logic [2:0] PH_BYTE0   = 3'd0;
   localparam logic [2:0] PH_BYTE1   = 3'd1;
   localparam logic [2:0] PH_EXTLEN  = 3'd2;
   localparam logic [2:0] PH_MASK    = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   // Seven-bit length codes that select an extended length field.
   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [2:0] MASK_BYTES  = 3'd4;

   // Header byte counts.
   localparam logic [3:0] HDR_LEN_BYTE0 = 4'd1;
   localparam logic [3:0] HDR_LEN_MIN   = 4'd2;
   localparam logic [3:0] HDR_LEN_MAX   = 4'd14;

endpackage

// ===== hw/rtl/websocket_frame_deframer_core.sv =====
// WebSocket frame deframer: parses a byte stream and unmasks the payload bytes.
// An accepted input beat passes through the input register and then the result register to rsp_.
// Throughput is one byte per clock while rsp_stall is low: the input register, the parse
// logic and the result register form a two-stage pipeline that never waits on its own state.
// Synchronous active-high reset clears the parser state and both valid flags;
// after reset the parser waits for the first header byte of a frame.
module websocket_frame_deframer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_payload,
   output logic        rsp_header_done,
   output logic        rsp_frame_end,
   output logic        rsp_fin_flag,
   output logic [3:0]  rsp_frame_opcode,
   output logic        rsp_mask_flag,
   output logic [63:0] rsp_payload_length,
   output logic [3:0]  rsp_header_length
);
   import wdf_pkg::*;

   // Input register.
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;

   // Parser state.
   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  ext_left_ff, ext_left_in;
   logic [63:0] len_acc_ff, len_acc_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [2:0]  mask_left_ff, mask_left_in;
   logic [63:0] pay_rem_ff, pay_rem_in;
   logic [1:0]  mask_pos_ff, mask_pos_in;
   logic        fin_ff, fin_in;
   logic        mask_bit_ff, mask_bit_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic [3:0]  hdr_cnt_ff, hdr_cnt_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        is_payload_ff, is_payload_in;
   logic        header_done_ff, header_done_in;
   logic        frame_end_ff, frame_end_in;
   logic [3:0]  header_length_ff, header_length_in;

   logic        out_free;
   logic        step;
   logic        in_load;
   logic        do_finish;
   logic [7:0]  key_byte;

   // The result register frees up when empty or when its beat is taken.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign in_load   = req_valid && !req_stall;

   always_comb begin
      if (in_load) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      case (mask_pos_ff)
         2'd0: key_byte = mask_key_ff[31:24];
         2'd1: key_byte = mask_key_ff[23:16];
         2'd2: key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in       = phase_ff;
      ext_left_in    = ext_left_ff;
      len_acc_in     = len_acc_ff;
      mask_key_in    = mask_key_ff;
      mask_left_in   = mask_left_ff;
      pay_rem_in     = pay_rem_ff;
      mask_pos_in    = mask_pos_ff;
      fin_in         = fin_ff;
      mask_bit_in    = mask_bit_ff;
      opcode_in      = opcode_ff;
      hdr_cnt_in     = hdr_cnt_ff;
      out_byte_in    = 8'd0;
      is_payload_in  = 1'b0;
      header_done_in = 1'b0;
      frame_end_in   = 1'b0;
      do_finish      = 1'b0;

      case (phase_ff)
         PH_BYTE1: begin
            mask_bit_in = in_byte_ff[7];
            hdr_cnt_in  = HDR_LEN_MIN;
            len_acc_in  = 64'd0;
            if (in_byte_ff[6:0] == LEN7_EXT16) begin
               ext_left_in = EXT16_BYTES;
               phase_in    = PH_EXTLEN;
            end else if (in_byte_ff[6:0] == LEN7_EXT64) begin
               ext_left_in = EXT64_BYTES;
               phase_in    = PH_EXTLEN;
            end else begin
               len_acc_in = {57'd0, in_byte_ff[6:0]};
               if (in_byte_ff[7]) begin
                  mask_left_in = MASK_BYTES;
                  phase_in     = PH_MASK;
               end else begin
                  do_finish = 1'b1;
               end
            end
         end
         PH_EXTLEN: begin
            len_acc_in  = {len_acc_ff[55:0], in_byte_ff};
            hdr_cnt_in  = hdr_cnt_ff + 4'd1;
            ext_left_in = ext_left_ff - 4'd1;
            if (ext_left_in == 4'd0) begin
               if (mask_bit_ff) begin
                  mask_left_in = MASK_BYTES;
                  phase_in     = PH_MASK;
               end else begin
                  do_finish = 1'b1;
               end
            end
         end
         PH_MASK: begin
            mask_key_in  = {mask_key_ff[23:0], in_byte_ff};
            hdr_cnt_in   = hdr_cnt_ff + 4'd1;
            mask_left_in = mask_left_ff - 3'd1;
            if (mask_left_in == 3'd0) begin
               do_finish = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            out_byte_in   = mask_bit_ff ? (in_byte_ff ^ key_byte) : in_byte_ff;
            is_payload_in = 1'b1;
            mask_pos_in   = mask_pos_ff + 2'd1;
            pay_rem_in    = pay_rem_ff - 64'd1;
            if (pay_rem_in == 64'd0) begin
               frame_end_in = 1'b1;
               phase_in     = PH_BYTE0;
            end
         end
         default: begin
            // First header byte; unused phase codes also land here.
            fin_in       = in_byte_ff[7];
            opcode_in    = in_byte_ff[3:0];
            mask_bit_in  = 1'b0;
            hdr_cnt_in   = HDR_LEN_BYTE0;
            len_acc_in   = 64'd0;
            mask_key_in  = 32'd0;
            mask_pos_in  = 2'd0;
            pay_rem_in   = 64'd0;
            ext_left_in  = 4'd0;
            mask_left_in = 3'd0;
            phase_in     = PH_BYTE1;
         end
      endcase

      // A frame with an empty payload ends on its last header byte.
      if (do_finish) begin
         header_done_in = 1'b1;
         pay_rem_in     = len_acc_in;
         mask_pos_in    = 2'd0;
         if (len_acc_in == 64'd0) begin
            frame_end_in = 1'b1;
            phase_in     = PH_BYTE0;
         end else begin
            phase_in = PH_PAYLOAD;
         end
      end

      if (header_done_in || is_payload_in || phase_in == PH_PAYLOAD) begin
         header_length_in = hdr_cnt_in;
      end else begin
         header_length_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_BYTE0;
         ext_left_ff  <= 4'd0;
         len_acc_ff   <= 64'd0;
         mask_key_ff  <= 32'd0;
         mask_left_ff <= 3'd0;
         pay_rem_ff   <= 64'd0;
         mask_pos_ff  <= 2'd0;
         fin_ff       <= 1'b0;
         mask_bit_ff  <= 1'b0;
         opcode_ff    <= 4'd0;
         hdr_cnt_ff   <= 4'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            phase_ff     <= phase_in;
            ext_left_ff  <= ext_left_in;
            len_acc_ff   <= len_acc_in;
            mask_key_ff  <= mask_key_in;
            mask_left_ff <= mask_left_in;
            pay_rem_ff   <= pay_rem_in;
            mask_pos_ff  <= mask_pos_in;
            fin_ff       <= fin_in;
            mask_bit_ff  <= mask_bit_in;
            opcode_ff    <= opcode_in;
            hdr_cnt_ff   <= hdr_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_byte_ff <= req_data_byte;
      end
      if (step) begin
         out_byte_ff      <= out_byte_in;
         is_payload_ff    <= is_payload_in;
         header_done_ff   <= header_done_in;
         frame_end_ff     <= frame_end_in;
         header_length_ff <= header_length_in;
      end
   end

   // Frame fields and length come straight from the state, which only moves with the result.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_is_payload     = is_payload_ff;
   assign rsp_header_done    = header_done_ff;
   assign rsp_frame_end      = frame_end_ff;
   assign rsp_fin_flag       = fin_ff;
   assign rsp_frame_opcode   = opcode_ff;
   assign rsp_mask_flag      = mask_bit_ff;
   assign rsp_payload_length = len_acc_ff;
   assign rsp_header_length  = header_length_ff;

endmodule

// ===== hw/rtl/wdf_checker.sv =====
// Port-level checks for the WebSocket frame deframer, bound to its top level.
`include "assert_macros.svh"

module wdf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_is_payload,
   input logic        rsp_header_done,
   input logic [3:0]  rsp_header_length
);
   import wdf_pkg::*;

   // A result beat that is held off stays offered.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // Header bytes never carry a data byte.
   `ASSERT_SAME(a_nonpayload_zero, clock, reset, rsp_valid && !rsp_is_payload,
                rsp_out_byte == 8'd0)

   // A finished header has a legal size.
   `ASSERT_SAME(a_hdr_len_range, clock, reset, rsp_valid && rsp_header_done,
                rsp_header_length >= HDR_LEN_MIN && rsp_header_length <= HDR_LEN_MAX)

   // Payload beats only follow a complete header and never coincide with it.
   `ASSERT_SAME(a_payload_after_hdr, clock, reset, rsp_valid && rsp_is_payload,
                !rsp_header_done && rsp_header_length >= HDR_LEN_MIN)

endmodule

bind websocket_frame_deframer_core wdf_checker u_wdf_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_out_byte       (rsp_out_byte),
   .rsp_is_payload     (rsp_is_payload),
   .rsp_header_done    (rsp_header_done),
   .rsp_header_length  (rsp_header_length)
);

// ===== tb/tb_websocket_frame_deframer_core.sv =====
// Self-checking testbench for the WebSocket frame deframer core.
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_core;
   import wdf_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_CYCLES  = 150;
   localparam int HOLD_AFTER   = 400;
   localparam int STREAM_BYTES = 1530;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        is_payload;
      logic        header_done;
      logic        frame_end;
      logic        fin;
      logic [3:0]  opcode;
      logic        mask;
      logic [63:0] payload_length;
      logic [3:0]  header_length;
   } deframe_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_is_payload;
   logic        rsp_header_done;
   logic        rsp_frame_end;
   logic        rsp_fin_flag;
   logic [3:0]  rsp_frame_opcode;
   logic        rsp_mask_flag;
   logic [63:0] rsp_payload_length;
   logic [3:0]  rsp_header_length;

   websocket_frame_deframer_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_is_payload     (rsp_is_payload),
      .rsp_header_done    (rsp_header_done),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_fin_flag       (rsp_fin_flag),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_mask_flag      (rsp_mask_flag),
      .rsp_payload_length (rsp_payload_length),
      .rsp_header_length  (rsp_header_length)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Byte stream still to be sent and results still to be seen.
   logic [7:0]         frame_bytes [$];
   deframe_result_type expected_results [$];
   int                 errors = 0;

   // Parser state mirrored by the predictor.
   logic [2:0]  frame_phase;
   logic [3:0]  ext_left;
   logic [63:0] len_acc;
   logic [31:0] key;
   logic [2:0]  key_left;
   logic [63:0] bytes_left;
   logic [1:0]  key_pos;
   logic        hdr_fin;
   logic        hdr_mask;
   logic [3:0]  hdr_opcode;
   logic [3:0]  hdr_count;

   // Short frames with the field extremes, a masked and an unmasked frame, reserved
   // bits and opcodes, and a zero length coded in a needless 16-bit field.
   logic [7:0] directed_bytes [0:23] = '{
      8'h81, 8'h00,
      8'h0F, 8'h80, 8'hA5, 8'h5A, 8'hFF, 8'h00,
      8'h7A, 8'h83, 8'hFF, 8'h00, 8'h3C, 8'hC3, 8'h00, 8'hFF, 8'h5A,
      8'h82, 8'h7E, 8'h00, 8'h00,
      8'hF0, 8'h01, 8'hAB
   };

   task automatic predict_beat(input logic [7:0] b);
      deframe_result_type r;
      logic [7:0]         key_byte;
      r = '0;
      case (frame_phase)
         PH_BYTE1: begin
            hdr_mask  = b[7];
            hdr_count = HDR_LEN_MIN;
            len_acc   = '0;
            if (b[6:0] == LEN7_EXT16) begin
               ext_left    = EXT16_BYTES;
               frame_phase = PH_EXTLEN;
            end else if (b[6:0] == LEN7_EXT64) begin
               ext_left    = EXT64_BYTES;
               frame_phase = PH_EXTLEN;
            end else begin
               len_acc = 64'(b[6:0]);
               if (hdr_mask) begin
                  key_left    = MASK_BYTES;
                  frame_phase = PH_MASK;
               end else begin
                  r.header_done = 1'b1;
               end
            end
         end
         PH_EXTLEN: begin
            len_acc   = {len_acc[55:0], b};
            hdr_count = hdr_count + 1'b1;
            ext_left  = ext_left - 1'b1;
            if (ext_left == '0) begin
               if (hdr_mask) begin
                  key_left    = MASK_BYTES;
                  frame_phase = PH_MASK;
               end else begin
                  r.header_done = 1'b1;
               end
            end
         end
         PH_MASK: begin
            key       = {key[23:0], b};
            hdr_count = hdr_count + 1'b1;
            key_left  = key_left - 1'b1;
            if (key_left == '0) r.header_done = 1'b1;
         end
         PH_PAYLOAD: begin
            // Key bytes are used most significant first.
            key_byte     = hdr_mask ? 8'(key >> {~key_pos, 3'b000}) : 8'h00;
            r.out_byte   = b ^ key_byte;
            r.is_payload = 1'b1;
            key_pos      = key_pos + 1'b1;
            bytes_left   = bytes_left - 1'b1;
            if (bytes_left == '0) begin
               r.frame_end = 1'b1;
               frame_phase = PH_BYTE0;
            end
         end
         default: begin
            hdr_fin     = b[7];
            hdr_opcode  = b[3:0];
            hdr_mask    = 1'b0;
            hdr_count   = HDR_LEN_BYTE0;
            len_acc     = '0;
            key         = '0;
            key_pos     = '0;
            bytes_left  = '0;
            ext_left    = '0;
            key_left    = '0;
            frame_phase = PH_BYTE1;
         end
      endcase
      if (r.header_done) begin
         bytes_left = len_acc;
         key_pos    = '0;
         if (len_acc == '0) begin
            r.frame_end = 1'b1;
            frame_phase = PH_BYTE0;
         end else begin
            frame_phase = PH_PAYLOAD;
         end
      end
      r.fin            = hdr_fin;
      r.opcode         = hdr_opcode;
      r.mask           = hdr_mask;
      r.payload_length = len_acc;
      r.header_length  = (r.header_done || frame_phase == PH_PAYLOAD || r.is_payload)
                         ? hdr_count : 4'd0;
      expected_results.push_back(r);
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= 10)
            $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      end
   endfunction

   // Appends one well-formed frame; most lengths are short, some use the extended fields.
   task automatic add_random_frame();
      logic [7:0]  b0;
      logic        masked;
      logic [63:0] len;
      int          kind;
      b0     = 8'($urandom);
      masked = 1'($urandom_range(1, 0));
      kind   = $urandom_range(9, 0);
      frame_bytes.push_back(b0);
      if (kind < 6) begin
         len = 64'(($urandom_range(3, 0) == 0) ? $urandom_range(125, 0) : $urandom_range(12, 0));
         frame_bytes.push_back({masked, len[6:0]});
      end else if (kind < 9) begin
         len = 64'((kind == 8) ? $urandom_range(20, 0) : $urandom_range(300, 0));
         frame_bytes.push_back({masked, LEN7_EXT16});
         frame_bytes.push_back(len[15:8]);
         frame_bytes.push_back(len[7:0]);
      end else begin
         len = 64'($urandom_range(40, 0));
         frame_bytes.push_back({masked, LEN7_EXT64});
         for (int i = 7; i >= 0; i--) frame_bytes.push_back(len[8*i +: 8]);
      end
      if (masked)
         for (int i = 0; i < 4; i++) frame_bytes.push_back(8'($urandom));
      for (int i = 0; i < int'(len); i++) frame_bytes.push_back(8'($urandom));
   endtask

   // Driver: bursts of random length separated by random gaps.
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         req_data_byte <= 8'h00;
         burst_left = 1;
         gap_left   = 0;
      end else if (req_valid && req_stall) begin
         // The stalled beat stays on the bus unchanged.
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (frame_bytes.size() > 0) begin
         req_valid     <= 1'b1;
         req_data_byte <= frame_bytes.pop_front();
         burst_left--;
         if (burst_left == 0) begin
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(200, 50)
                                                     : $urandom_range(12, 1);
            gap_left   = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(6, 1);
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: stall pattern changes from stretch to stretch, plus one long hold-off.
   int stall_mode;
   int mode_cycles;
   int hold_left;
   int results_taken;
   bit hold_done;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode    = 0;
         mode_cycles   = 0;
         hold_left     = 0;
         results_taken = 0;
         hold_done     = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) results_taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && results_taken >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               1:       rsp_stall <= ($urandom_range(7, 0) == 0);
               2:       rsp_stall <= 1'($urandom_range(1, 0));
               3:       rsp_stall <= ((mode_cycles % 5) < 2);
               default: rsp_stall <= 1'b0;
            endcase
         end
         if (mode_cycles == 0) begin
            stall_mode  = $urandom_range(3, 0);
            mode_cycles = $urandom_range(100, 20);
         end else begin
            mode_cycles--;
         end
      end
   end

   // Monitor: predicts each accepted byte, then checks each accepted result.
   always @(posedge clock) begin
      deframe_result_type want;
      if (reset) begin
         frame_phase = PH_BYTE0;
         ext_left    = '0;
         len_acc     = '0;
         key         = '0;
         key_left    = '0;
         bytes_left  = '0;
         key_pos     = '0;
         hdr_fin     = 1'b0;
         hdr_mask    = 1'b0;
         hdr_opcode  = '0;
         hdr_count   = '0;
      end else begin
         if (req_valid && !req_stall) predict_beat(req_data_byte);
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= 10) $display("result beat with no byte waiting for it");
            end else begin
               want = expected_results.pop_front();
               check_field("out_byte", want.out_byte, rsp_out_byte);
               check_field("is_payload", want.is_payload, rsp_is_payload);
               check_field("header_done", want.header_done, rsp_header_done);
               check_field("frame_end", want.frame_end, rsp_frame_end);
               check_field("fin_flag", want.fin, rsp_fin_flag);
               check_field("frame_opcode", want.opcode, rsp_frame_opcode);
               check_field("mask_flag", want.mask, rsp_mask_flag);
               check_field("payload_length", want.payload_length, rsp_payload_length);
               check_field("header_length", want.header_length, rsp_header_length);
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a beat.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [63:0] huge_len;
      foreach (directed_bytes[i]) frame_bytes.push_back(directed_bytes[i]);
      while (frame_bytes.size() < STREAM_BYTES) add_random_frame();
      // Last frame: 64-bit length with the top bit set, so the parser stays in payload.
      huge_len = {1'b1, 63'({$urandom, $urandom})};
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back({1'b1, LEN7_EXT64});
      for (int i = 7; i >= 0; i--) frame_bytes.push_back(huge_len[8*i +: 8]);
      for (int i = 0; i < 20; i++) frame_bytes.push_back(8'($urandom));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (frame_bytes.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0 && expected_results.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/wdf_pkg.sv
hw/rtl/websocket_frame_deframer_core.sv
hw/rtl/wdf_checker.sv
tb/tb_websocket_frame_deframer_core.sv
